// ===== sv/hvd_pkg.sv =====
// ----------------------------------------------------------------------------
// hvd_pkg: shared types and constants of the HMM Viterbi decoder
// Item kinds, field widths and the control group passed to each ACS lane.
// ----------------------------------------------------------------------------
package hvd_pkg;

  // Field widths of the stream items.
  localparam int OP_W       = 2;
  localparam int IDX_W      = 2;
  localparam int VAL_W      = 32;
  localparam int POS_OUT_W  = 10;
  localparam int TOTAL_W    = 48;
  localparam int IN_DATA_W  = 168;
  localparam int OUT_DATA_W = 96;

  // Operation carried in the input tuser.
  typedef enum logic [OP_W-1:0] {
    OP_TRANS = 2'd0,
    OP_INIT  = 2'd1,
    OP_OBS   = 2'd2,
    OP_READ  = 2'd3
  } op_t;

  // Kind of a result travelling down the pipeline.
  typedef enum logic {
    K_OBS_END = 1'b0,
    K_READ    = 1'b1
  } item_kind_t;

  // Control of one add-compare-select lane.
  typedef struct packed {
    logic first;    // first observation of a sequence
    logic lane_on;  // lane is below the active state count
  } acs_ctl_t;

endpackage

// ===== sv/hvd_acs_lane.sv =====
// ----------------------------------------------------------------------------
// hvd_acs_lane: one add-compare-select lane
// Computes the new path score and survivor of one state for one observation.
// ----------------------------------------------------------------------------
module hvd_acs_lane #(
  parameter int NUM_STATES  = 4,
  parameter int SCORE_WIDTH = 32,
  parameter int SW          = 2
) (
  input  hvd_pkg::acs_ctl_t                        ctl,
  input  logic [NUM_STATES-1:0]                    active_mask,
  input  logic [NUM_STATES-1:0][SCORE_WIDTH-1:0]   scores,
  input  logic [NUM_STATES-1:0][SCORE_WIDTH-1:0]   trans_col,
  input  logic [SCORE_WIDTH-1:0]                   init_val,
  input  logic [SCORE_WIDTH-1:0]                   emit,
  output logic [SCORE_WIDTH-1:0]                   fresh,
  output logic [SW-1:0]                            surv
);

  localparam logic [SCORE_WIDTH-1:0] SMIN = {1'b1, {(SCORE_WIDTH-1){1'b0}}};
  localparam logic [SCORE_WIDTH-1:0] SMAX = {1'b0, {(SCORE_WIDTH-1){1'b1}}};

  // Saturating log-domain add; log zero absorbs.
  function automatic logic [SCORE_WIDTH-1:0] ladd(input logic [SCORE_WIDTH-1:0] a,
                                                  input logic [SCORE_WIDTH-1:0] b);
    logic [SCORE_WIDTH:0] sum;
    sum = {a[SCORE_WIDTH-1], a} + {b[SCORE_WIDTH-1], b};
    if (a == SMIN || b == SMIN) return SMIN;
    if (sum[SCORE_WIDTH] != sum[SCORE_WIDTH-1]) return sum[SCORE_WIDTH] ? SMIN : SMAX;
    return sum[SCORE_WIDTH-1:0];
  endfunction

  logic signed [SCORE_WIDTH-1:0] top;
  logic signed [SCORE_WIDTH-1:0] cand;
  logic [SW-1:0]                 arg;

  // Compare candidates in state order; only a strictly larger one wins.
  always_comb begin
    top = signed'(ladd(scores[0], trans_col[0]));
    arg = '0;
    for (int s = 1; s < NUM_STATES; s++) begin
      cand = signed'(ladd(scores[s], trans_col[s]));
      if (active_mask[s] && cand > top) begin
        top = cand;
        arg = SW'(s);
      end
    end
    if (!ctl.lane_on) begin
      fresh = SMIN;
      surv  = '0;
    end else if (ctl.first) begin
      fresh = ladd(emit, init_val);
      surv  = '0;
    end else begin
      fresh = ladd(top, emit);
      surv  = arg;
    end
  end

endmodule

// ===== sv/hvd_merge.sv =====
// ----------------------------------------------------------------------------
// hvd_merge: end-state selection
// Picks the best active lane score, ties going to the lowest state.
// ----------------------------------------------------------------------------
module hvd_merge #(
  parameter int NUM_STATES  = 4,
  parameter int SCORE_WIDTH = 32,
  parameter int SW          = 2
) (
  input  logic [NUM_STATES-1:0]                  active_mask,
  input  logic [NUM_STATES-1:0][SCORE_WIDTH-1:0] scores,
  output logic [SW-1:0]                          best_idx,
  output logic [SCORE_WIDTH-1:0]                 best_score
);

  logic signed [SCORE_WIDTH-1:0] top;

  // Linear scan over the lanes.
  always_comb begin
    top      = signed'(scores[0]);
    best_idx = '0;
    for (int s = 1; s < NUM_STATES; s++) begin
      if (active_mask[s] && signed'(scores[s]) > top) begin
        top      = signed'(scores[s]);
        best_idx = SW'(s);
      end
    end
    best_score = top;
  end

endmodule

// ===== sv/hvd_surv_mem.sv =====
// ----------------------------------------------------------------------------
// hvd_surv_mem: survivor store
// One row per observation holding the survivor of every state; registered read.
// ----------------------------------------------------------------------------
module hvd_surv_mem #(
  parameter int DEPTH = 1024,
  parameter int ROW_W = 8,
  parameter int AW    = 10
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [ROW_W-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [ROW_W-1:0] rdata
);

  logic [ROW_W-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, data held until the next read.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/hmm_viterbi_decoder.sv =====
// ----------------------------------------------------------------------------
// hmm_viterbi_decoder: log-domain HMM Viterbi decoder
// Parallel ACS lanes score one observation a cycle while s_axis_tready is high;
// survivors go to a memory and read items trace the best path backwards.
//
//   Channel  Dir  Signals                 Carries
//   s_axis   in   tvalid tready tdata ..  loads, observations, read requests
//   m_axis   out  tvalid tready tdata ..  end-state reports and path elements
//   cfg      in   cfg_we cfg_wdata        active state count
//
// One item is accepted per cycle while stage B has room; the ACS lane loop over
// previous states sets the clock period. Results pass stages B, C and output.
// Reset clears scores, positions, the total and the pipeline; the tables and
// the survivor memory hold nothing defined until written.
// A stalled output holds the two pipeline registers; input is still taken
// while they have room.
// ----------------------------------------------------------------------------
module hmm_viterbi_decoder #(
  parameter int NUM_STATES  = 4,
  parameter int MAX_SEQ_LEN = 1024,
  parameter int SCORE_WIDTH = 32
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [2:0]                       cfg_wdata,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // from_state, to_state, load_value, emit_0, emit_1, emit_2, emit_3, zero fill
  input  logic [hvd_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  input  logic                             s_axis_tlast,   // last_obs
  input  logic [hvd_pkg::OP_W-1:0]         s_axis_tuser,   // op
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // path_state, position, seq_score, total_score, zero fill
  output logic [hvd_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  output logic                             m_axis_tlast,   // path_done
  output logic                             m_axis_tuser    // overflow
);

  localparam int SW    = (NUM_STATES > 1) ? $clog2(NUM_STATES) : 1;
  localparam int PW    = $clog2(MAX_SEQ_LEN);
  localparam int ROW_W = NUM_STATES * SW;
  localparam logic [SCORE_WIDTH-1:0] SMIN = {1'b1, {(SCORE_WIDTH-1){1'b0}}};
  localparam logic [SCORE_WIDTH-1:0] SMAX = {1'b0, {(SCORE_WIDTH-1){1'b1}}};
  localparam logic signed [48:0] SMAX_W = (49'sd1 <<< (SCORE_WIDTH-1)) - 49'sd1;
  localparam logic signed [48:0] SMIN_W = -SMAX_W - 49'sd1;
  localparam logic signed [48:0] I32MAX = 49'sd2147483647;
  localparam logic signed [48:0] I32MIN = -49'sd2147483648;

  // Field value to score domain; the most negative field is log zero.
  function automatic logic [SCORE_WIDTH-1:0] cvt(input logic [31:0] v);
    logic signed [48:0] w;
    w = 49'(signed'(v));
    if (v == 32'h8000_0000) return SMIN;
    if (w > SMAX_W) return SMAX;
    if (w < SMIN_W) return SMIN;
    return w[SCORE_WIDTH-1:0];
  endfunction

  // Input fields.
  hvd_pkg::op_t op;
  logic [1:0]   from_state, to_state;
  logic [31:0]  load_value;
  logic         acc;

  assign op         = hvd_pkg::op_t'(s_axis_tuser);
  assign from_state = s_axis_tdata[1:0];
  assign to_state   = s_axis_tdata[3:2];
  assign load_value = s_axis_tdata[35:4];
  assign acc        = s_axis_tvalid && s_axis_tready;

  // Configuration and lane mask.
  logic [2:0]            active_states;
  logic [2:0]            n_lanes;
  logic [NUM_STATES-1:0] active_mask;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_states <= 3'(NUM_STATES);
    end else if (cfg_we) begin
      active_states <= cfg_wdata;
    end
  end

  always_comb begin
    if (active_states == 3'd0) n_lanes = 3'd1;
    else if (active_states > 3'(NUM_STATES)) n_lanes = 3'(NUM_STATES);
    else n_lanes = active_states;
    for (int t = 0; t < NUM_STATES; t++) begin
      active_mask[t] = 3'(t) < n_lanes;
    end
  end

  // Transition and initial tables.
  logic [NUM_STATES-1:0][NUM_STATES-1:0][SCORE_WIDTH-1:0] trans;
  logic [NUM_STATES-1:0][SCORE_WIDTH-1:0]                 init_tab;

  always_ff @(posedge clk) begin
    if (acc && op == hvd_pkg::OP_TRANS && {1'b0, from_state} < 3'(NUM_STATES)
        && {1'b0, to_state} < 3'(NUM_STATES)) begin
      trans[from_state[SW-1:0]][to_state[SW-1:0]] <= cvt(load_value);
    end
    if (acc && op == hvd_pkg::OP_INIT && {1'b0, to_state} < 3'(NUM_STATES)) begin
      init_tab[to_state[SW-1:0]] <= cvt(load_value);
    end
  end

  // ACS lanes.
  logic [NUM_STATES-1:0][SCORE_WIDTH-1:0] path_scores;
  logic [NUM_STATES-1:0][SCORE_WIDTH-1:0] fresh;
  logic [ROW_W-1:0]                       surv_row;
  logic [PW:0]                            seq_position;
  logic                                   first_obs;

  assign first_obs = seq_position == '0;

  for (genvar t = 0; t < NUM_STATES; t++) begin : g_lane
    logic [NUM_STATES-1:0][SCORE_WIDTH-1:0] col;
    hvd_pkg::acs_ctl_t                      ctl;
    for (genvar s = 0; s < NUM_STATES; s++) begin : g_col
      assign col[s] = trans[s][t];
    end
    assign ctl.first   = first_obs;
    assign ctl.lane_on = active_mask[t];
    hvd_acs_lane #(
      .NUM_STATES (NUM_STATES),
      .SCORE_WIDTH(SCORE_WIDTH),
      .SW         (SW)
    ) u_lane (
      .ctl        (ctl),
      .active_mask(active_mask),
      .scores     (path_scores),
      .trans_col  (col),
      .init_val   (init_tab[t]),
      .emit       (cvt(s_axis_tdata[36 + 32*t +: 32])),
      .fresh      (fresh[t]),
      .surv       (surv_row[t*SW +: SW])
    );
  end

  // Sequence and trace bookkeeping at transfer.
  logic            overflow_flag, ovf_next;
  logic [PW-1:0]   trace_position, tp_next;
  logic [PW:0]     pos_after;
  logic            in_range, obs_acc, read_acc, lookup, push;

  assign in_range = seq_position < (PW+1)'(MAX_SEQ_LEN);
  assign obs_acc  = acc && op == hvd_pkg::OP_OBS;
  assign read_acc = acc && op == hvd_pkg::OP_READ;

  always_comb begin
    ovf_next  = first_obs ? 1'b0 : overflow_flag;
    pos_after = seq_position;
    if (in_range) pos_after = seq_position + 1'b1;
    else ovf_next = 1'b1;
    lookup  = trace_position != '0;
    tp_next = lookup ? trace_position - 1'b1 : '0;
    push    = read_acc || (obs_acc && s_axis_tlast);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      path_scores    <= '0;
      seq_position   <= '0;
      overflow_flag  <= 1'b0;
      trace_position <= '0;
    end else begin
      if (obs_acc) begin
        overflow_flag <= ovf_next;
        if (in_range) path_scores <= fresh;
        if (s_axis_tlast) begin
          seq_position   <= '0;
          trace_position <= PW'(pos_after - 1'b1);
        end else begin
          seq_position <= pos_after;
        end
      end
      if (read_acc) trace_position <= tp_next;
    end
  end

  // Survivor memory.
  logic [ROW_W-1:0] row_rd;

  hvd_surv_mem #(
    .DEPTH(MAX_SEQ_LEN),
    .ROW_W(ROW_W),
    .AW   (PW)
  ) u_surv (
    .clk  (clk),
    .we   (obs_acc && in_range),
    .waddr(seq_position[PW-1:0]),
    .wdata(surv_row),
    .re   (read_acc),
    .raddr(trace_position),
    .rdata(row_rd)
  );

  // Pipeline handshake: output register, stage C, stage B.
  logic adv_out, c_free, b_free, b_move, c_move;
  logic b_valid, c_valid;

  assign adv_out       = !m_axis_tvalid || m_axis_tready;
  assign c_move        = c_valid && adv_out;
  assign c_free        = !c_valid || adv_out;
  assign b_move        = b_valid && c_free;
  assign b_free        = !b_valid || c_free;
  assign s_axis_tready = b_free;

  // Stage B registers.
  hvd_pkg::item_kind_t b_kind;
  logic [PW-1:0]       b_pos;
  logic                b_ovf, b_lookup;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (b_free) begin
      b_valid <= push;
    end
  end

  always_ff @(posedge clk) begin
    if (b_free && push) begin
      b_kind   <= read_acc ? hvd_pkg::K_READ : hvd_pkg::K_OBS_END;
      b_pos    <= read_acc ? tp_next : PW'(pos_after - 1'b1);
      b_ovf    <= read_acc ? overflow_flag : ovf_next;
      b_lookup <= read_acc && lookup;
    end
  end

  // Stage B: end-state merge or trace step.
  logic [SW-1:0]          best_idx, trace_state, b_state;
  logic [SCORE_WIDTH-1:0] best_score;

  hvd_merge #(
    .NUM_STATES (NUM_STATES),
    .SCORE_WIDTH(SCORE_WIDTH),
    .SW         (SW)
  ) u_merge (
    .active_mask(active_mask),
    .scores     (path_scores),
    .best_idx   (best_idx),
    .best_score (best_score)
  );

  always_comb begin
    unique case (b_kind)
      hvd_pkg::K_OBS_END: b_state = best_idx;
      hvd_pkg::K_READ:    b_state = b_lookup ? row_rd[trace_state*SW +: SW] : trace_state;
      default:            b_state = trace_state;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      trace_state <= '0;
    end else if (b_move) begin
      trace_state <= b_state;
    end
  end

  // Stage C registers.
  hvd_pkg::item_kind_t    c_kind;
  logic [SW-1:0]          c_state;
  logic [PW-1:0]          c_pos;
  logic                   c_ovf;
  logic [SCORE_WIDTH-1:0] c_score;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (c_free) begin
      c_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (b_move) begin
      c_kind  <= b_kind;
      c_state <= b_state;
      c_pos   <= b_pos;
      c_ovf   <= b_ovf;
      c_score <= best_score;
    end
  end

  // Stage C: running total and result formatting.
  logic [hvd_pkg::TOTAL_W-1:0] running_total, tot_next, tot_out;
  logic [hvd_pkg::TOTAL_W:0]   tot_sum;
  logic signed [48:0]          score_w;
  logic [31:0]                 seq_out;

  always_comb begin
    score_w = 49'(signed'(c_score));
    tot_sum = {running_total[hvd_pkg::TOTAL_W-1], running_total} + score_w;
    if (tot_sum[hvd_pkg::TOTAL_W] != tot_sum[hvd_pkg::TOTAL_W-1]) begin
      tot_next = tot_sum[hvd_pkg::TOTAL_W] ? {1'b1, {(hvd_pkg::TOTAL_W-1){1'b0}}}
                                           : {1'b0, {(hvd_pkg::TOTAL_W-1){1'b1}}};
    end else begin
      tot_next = tot_sum[hvd_pkg::TOTAL_W-1:0];
    end
    if (score_w > I32MAX) seq_out = 32'h7FFF_FFFF;
    else if (score_w < I32MIN) seq_out = 32'h8000_0000;
    else seq_out = score_w[31:0];
    tot_out = running_total;
    if (c_kind == hvd_pkg::K_OBS_END) begin
      tot_out = tot_next;
    end else begin
      seq_out = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_total <= '0;
    end else if (c_move && c_kind == hvd_pkg::K_OBS_END) begin
      running_total <= tot_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (c_move) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (c_move) begin
      m_axis_tdata <= {4'b0, tot_out, seq_out, hvd_pkg::POS_OUT_W'(c_pos), 2'(c_state)};
      m_axis_tlast <= c_pos == '0;
      m_axis_tuser <= c_ovf;
    end
  end

  // Checks on the pipeline and bookkeeping.
  a_cmove_out: assert property (@(posedge clk) disable iff (rst)
    c_move |=> m_axis_tvalid)
    else $error("result leaving stage C did not reach the output");
  a_seq_bound: assert property (@(posedge clk) disable iff (rst)
    seq_position <= (PW+1)'(MAX_SEQ_LEN))
    else $error("sequence position beyond store length");
  a_trace_hold: assert property (@(posedge clk) disable iff (rst)
    !acc |=> $stable(trace_position))
    else $error("trace position moved without a transfer");
  a_total_hold: assert property (@(posedge clk) disable iff (rst)
    !c_move |=> $stable(running_total))
    else $error("running total moved without an end-of-sequence result");

endmodule
